### rtl/core/cwc_pkg.sv
`timescale 1ns / 1ps

package cwc_pkg;

	// fixed field widths of the stream items
	localparam int COORD_W   = 12;
	localparam int INDEX_W   = 6;
	localparam int COUNT_W   = 7;
	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 8;

	// defaults for the top level parameters
	localparam int MAX_WALLS_DEF  = 64;
	localparam int COORD_BITS_DEF = 12;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// status of the shared root unit
	typedef struct packed {
		logic done;
		logic exact;
	} sq_stat_t;

endpackage

### rtl/core/cwc_ram.sv
`timescale 1ns / 1ps

module cwc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/cwc_isqrt.sv
`timescale 1ns / 1ps

module cwc_isqrt #(
	parameter int CW = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2*CW-1:0]     value,
	output logic [CW-1:0]       root,
	output cwc_pkg::sq_stat_t   stat
);

	import cwc_pkg::*;

	localparam int VW   = 2 * CW;
	localparam int CNTW = $clog2(CW);

	logic [VW-1:0]   v_q;
	logic [VW-1:0]   root_q;
	logic [VW-1:0]   bit_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [VW:0]     trial;
	logic            take;

	// one result bit per cycle, most significant first
	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = ({1'b0, v_q} >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(CW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			root_q <= '0;
			bit_q  <= VW'(1) << (VW - 2);
		end else if (busy_q) begin
			if (take) begin
				v_q    <= v_q - trial[VW-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root       = root_q[CW-1:0];
	assign stat.done  = done_q;
	assign stat.exact = (v_q == '0);

endmodule

### rtl/core/circle_wall_collision_check_unit.sv
`timescale 1ns / 1ps
// channel  signals                           item
// s        s_tvalid s_tready s_tdata s_tuser  load a wall or query a circle
// m        m_tvalid m_tready m_tdata          one position_free per query
// cfg      cfg_valid cfg_ready cfg_data       wall_count register
//
// a load is written to the wall table as it is taken; a query fetches and decodes
// each tested wall in turn, skips it when it is neither vertical nor horizontal,
// drops it when r^2 - dx^2 is negative and otherwise waits for the shared
// bit-serial root unit, and ends at the first hit
// s_tready is low for the whole query; the result waits in the output register
// and a new item is taken while it waits, a finished query holds while m is full
// reset clears control state only; the wall table is undefined until loaded

module circle_wall_collision_check_unit #(
	parameter int MAX_WALLS  = cwc_pkg::MAX_WALLS_DEF,
	parameter int COORD_BITS = cwc_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// wall_index, start x, start y, end x, end y,
	// center_x, center_y, radius, zero fill
	input  logic [cwc_pkg::S_TDATA_W-1:0] s_tdata,
	// op
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// position_free, zero fill
	output logic [cwc_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cwc_pkg::COUNT_W-1:0]   cfg_data
);

	import cwc_pkg::*;

	localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int NW = $clog2(MAX_WALLS + 1);
	localparam int SW = CW + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_SQUARE,
		ST_ROOT,
		ST_CHECK,
		ST_RESULT
	} state_t;

	state_t state_q;

	logic [COUNT_W-1:0] wall_count_q;
	logic [NW-1:0]      n_q;
	logic [NW-1:0]      idx_q;
	logic [CW-1:0]      cx_q, cy_q;
	logic [2*CW-1:0]    r2_q;
	logic [CW-1:0]      dx_q, sc_q, lo_q, hi_q;
	logic               free_q;
	logic               m_tvalid_q;
	logic               m_free_q;

	logic               s_acc;
	logic               load_acc;
	logic               query_acc;
	logic [31:0]        slot32;
	logic [CW-1:0]      rad_c;
	logic [2*CW-1:0]    r2_c;
	logic [NW-1:0]      n_c;

	logic [4*CW-1:0]    wr_data;
	logic [4*CW-1:0]    rd_data;
	logic [CW-1:0]      w_xs, w_ys, w_xe, w_ye;
	logic               vert, horiz;
	logic [CW-1:0]      w_c, pc_c, sc_c, a_c, b_c;
	logic [CW:0]        diff_c;
	logic [CW:0]        absd_c;

	logic [2*CW-1:0]    dsq_c;
	logic [2*CW:0]      d_c;
	logic               sq_start;
	logic [CW-1:0]      sq_root;
	sq_stat_t           sq_stat;

	logic signed [SW-1:0] sc_e, s_e, lo_e, hi_e, hi_x, lo_raw, lo_x;
	logic                 hit;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid && s_tready;
	assign load_acc  = s_acc && (s_tuser == OP_LOAD);
	assign query_acc = s_acc && (s_tuser == OP_QUERY);

	// table write straight from the load item
	assign slot32  = 32'(s_tdata[5:0]);
	assign wr_data = {s_tdata[42+CW-1:42], s_tdata[30+CW-1:30],
		s_tdata[18+CW-1:18], s_tdata[6+CW-1:6]};

	cwc_ram #(
		.WIDTH (4 * CW),
		.DEPTH (MAX_WALLS),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (load_acc && (slot32 < MAX_WALLS)),
		.wr_addr (slot32[AW-1:0]),
		.wr_data (wr_data),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign rad_c = s_tdata[78+CW-1:78];
	assign r2_c  = (2*CW)'(rad_c) * (2*CW)'(rad_c);
	assign n_c   = (32'(wall_count_q) > MAX_WALLS) ? NW'(MAX_WALLS) : NW'(wall_count_q);

	// wall decode: vertical first, then horizontal
	assign w_xs  = rd_data[CW-1:0];
	assign w_ys  = rd_data[2*CW-1:CW];
	assign w_xe  = rd_data[3*CW-1:2*CW];
	assign w_ye  = rd_data[4*CW-1:3*CW];
	assign vert  = (w_xs == w_xe);
	assign horiz = (w_ys == w_ye);

	always_comb begin
		if (vert) begin
			w_c  = w_xs;
			a_c  = w_ys;
			b_c  = w_ye;
			pc_c = cx_q;
			sc_c = cy_q;
		end else begin
			w_c  = w_ys;
			a_c  = w_xs;
			b_c  = w_xe;
			pc_c = cy_q;
			sc_c = cx_q;
		end
	end

	assign diff_c = {1'b0, w_c} - {1'b0, pc_c};
	assign absd_c = diff_c[CW] ? (~diff_c + 1'b1) : diff_c;

	// d = r^2 - dx^2, negative means no crossing
	assign dsq_c    = (2*CW)'(dx_q) * (2*CW)'(dx_q);
	assign d_c      = {1'b0, r2_q} - {1'b0, dsq_c};
	assign sq_start = (state_q == ST_SQUARE) && !d_c[2*CW];

	cwc_isqrt #(
		.CW (CW)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (d_c[2*CW-1:0]),
		.root   (sq_root),
		.stat   (sq_stat)
	);

	// lower crossing truncates toward zero when the root is inexact
	assign sc_e   = signed'({2'b00, sc_q});
	assign s_e    = signed'({2'b00, sq_root});
	assign lo_e   = signed'({2'b00, lo_q});
	assign hi_e   = signed'({2'b00, hi_q});
	assign hi_x   = sc_e + s_e;
	assign lo_raw = sc_e - s_e;
	assign lo_x   = (sq_stat.exact || lo_raw < 0) ? lo_raw : lo_raw - SW'(1);
	assign hit    = ((hi_x > lo_e) && (hi_x < hi_e)) || ((lo_x > lo_e) && (lo_x < hi_e));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			wall_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			n_q        <= '0;
			free_q     <= 1'b1;
			m_tvalid_q <= 1'b0;
			m_free_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_RESULT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (query_acc) begin
						idx_q   <= '0;
						n_q     <= n_c;
						free_q  <= 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (idx_q == n_q) begin
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (vert || horiz) begin
						state_q <= ST_SQUARE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_SQUARE: begin
					if (d_c[2*CW]) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_FETCH;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sq_stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (hit) begin
						free_q  <= 1'b0;
						state_q <= ST_RESULT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_free_q   <= free_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query operands and per-wall working values
	always_ff @(posedge clk) begin
		if (query_acc) begin
			cx_q <= s_tdata[54+CW-1:54];
			cy_q <= s_tdata[66+CW-1:66];
			r2_q <= r2_c;
		end
		if (state_q == ST_DECODE) begin
			dx_q <= absd_c[CW-1:0];
			sc_q <= sc_c;
			lo_q <= (a_c < b_c) ? a_c : b_c;
			hi_q <= (a_c < b_c) ? b_c : a_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - 1)'(0), m_free_q};

	a_root_in_root_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_stat.done |-> state_q == ST_ROOT)
		else $error("root unit finished outside the root state");

	a_query_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> !s_tready)
		else $error("input still ready after a query was taken");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> idx_q <= n_q)
		else $error("wall index ran past the wall count");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_RESULT)
		else $error("result shown without a finished query");

endmodule

### verif/tb_circle_wall_collision_check_unit.sv
`timescale 1ns / 1ps

module tb_circle_wall_collision_check_unit;
	import cwc_pkg::*;

	localparam int WALLS     = 64;
	localparam int COORD_MAX = 4095;
	localparam int ITEM_GOAL = 750;

	typedef enum int {
		ROW_CFG,
		ROW_LOAD,
		ROW_QUERY
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [COUNT_W-1:0] count;
		logic [INDEX_W-1:0] slot;
		logic [COORD_W-1:0] f0, f1, f2, f3;
		bit                 typed;
		bit                 typed_free;
	} stim_row_t;

	typedef struct packed {
		logic [COORD_W-1:0] xs, ys, xe, ye;
	} wall_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// wall_index, start x, start y, end x, end y,
	// center_x, center_y, radius, zero fill
	logic [S_TDATA_W-1:0] s_tdata;
	// op
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// position_free, zero fill
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [COUNT_W-1:0]   cfg_data;

	wall_t              wall_shadow [WALLS];
	logic [COUNT_W-1:0] wall_count_shadow;
	bit                 free_expected [$];
	stim_row_t          directed_rows [$];
	int                 mismatches;
	int                 items_sent;
	bit                 calm;

	circle_wall_collision_check_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#50ms;
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// floor square root, one result bit per step from the top
	function automatic longint root_floor(longint v);
		longint acc;
		longint trial;
		acc = 0;
		for (int k = 12; k >= 0; k--) begin
			trial = acc | (longint'(1) << k);
			if (trial * trial <= v)
				acc = trial;
		end
		return acc;
	endfunction

	// wall on line w of one axis, span a..b on the other; circle at (pc, sc)
	function automatic bit wall_crossed(longint w, longint a, longint b,
	                                    longint pc, longint sc, longint r);
		longint gap_to_line, d, s, hi_x, lo_x, lo, hi;
		gap_to_line = w - pc;
		d = r * r - gap_to_line * gap_to_line;
		if (d < 0)
			return 1'b0;
		s = root_floor(d);
		hi_x = sc + s;
		// lower crossing rounds toward zero, so non-exact roots drop by one above zero
		if (s * s == d || sc - s < 0)
			lo_x = sc - s;
		else
			lo_x = sc - s - 1;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (hi_x > lo && hi_x < hi) || (lo_x > lo && lo_x < hi);
	endfunction

	function automatic bit predict_position_free(logic [COORD_W-1:0] cx,
	                                             logic [COORD_W-1:0] cy,
	                                             logic [COORD_W-1:0] r);
		int    n;
		wall_t w;
		n = (wall_count_shadow > WALLS) ? WALLS : int'(wall_count_shadow);
		for (int i = 0; i < n; i++) begin
			w = wall_shadow[i];
			if (w.xs == w.xe) begin
				if (wall_crossed(w.xs, w.ys, w.ye, cx, cy, r))
					return 1'b0;
			end else if (w.ys == w.ye) begin
				if (wall_crossed(w.ys, w.xs, w.xe, cy, cx, r))
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what, int expected_val, int got_val);
		$display("mismatch: %s expected %0d got %0d at %0t", what, expected_val, got_val,
			$time);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (free_expected.size() == 0) begin
				report_mismatch("position_free with no query waiting", -1,
					int'(m_tdata[0]));
			end else begin
				if (m_tdata[0] !== free_expected[0])
					report_mismatch("position_free", int'(free_expected[0]),
						int'(m_tdata[0]));
				if (m_tdata[M_TDATA_W-1:1] !== '0)
					report_mismatch("m_tdata zero fill", 0, int'(m_tdata[M_TDATA_W-1:1]));
				void'(free_expected.pop_front());
			end
		end
	end

	// result side stalls
	initial begin
		int w;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			w = calm ? 0 : $urandom_range(0, 4);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			@(negedge clk);
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic logic [COORD_W-1:0] rnd_coord();
		return COORD_W'($urandom_range(0, COORD_MAX));
	endfunction

	function automatic logic [COORD_W-1:0] clip_coord(int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return COORD_W'(COORD_MAX);
		return COORD_W'(v);
	endfunction

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(op_t op, logic [INDEX_W-1:0] slot, wall_t w,
	                         logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
	                         logic [COORD_W-1:0] r, bit typed, bit typed_free);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {6'b0, r, cy, cx, w.ye, w.xe, w.ys, w.xs, slot};
		s_tuser  <= op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (op == OP_LOAD)
			wall_shadow[slot] = w;
		else
			free_expected.insert(free_expected.size(),
				typed ? typed_free : predict_position_free(cx, cy, r));
		@(negedge clk);
	endtask

	// sender holds off until every query has answered, then lets a load settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (free_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_wall_count(logic [COUNT_W-1:0] v);
		drain();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		wall_count_shadow = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(row_kind_t kind, int count, int slot, int f0, int f1, int f2,
	                       int f3, bit typed, bit typed_free);
		stim_row_t row;
		row.kind       = kind;
		row.count      = COUNT_W'(count);
		row.slot       = INDEX_W'(slot);
		row.f0         = COORD_W'(f0);
		row.f1         = COORD_W'(f1);
		row.f2         = COORD_W'(f2);
		row.f3         = COORD_W'(f3);
		row.typed      = typed;
		row.typed_free = typed_free;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	function automatic wall_t random_wall();
		wall_t w;
		int    kind, span, a, b;
		kind = $urandom_range(0, 19);
		span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, COORD_MAX)
		                                   : $urandom_range(0, 300);
		a = $urandom_range(0, COORD_MAX);
		b = ($urandom_range(0, 1) == 1) ? a + span : a - span;
		w.xs = rnd_coord();
		w.ys = rnd_coord();
		w.xe = rnd_coord();
		w.ye = rnd_coord();
		if (kind <= 8) begin
			w.xe = w.xs;
			w.ys = clip_coord(a);
			w.ye = clip_coord(b);
		end else if (kind <= 17) begin
			w.ye = w.ys;
			w.xs = clip_coord(a);
			w.xe = clip_coord(b);
		end else if (kind == 19) begin
			// degenerate point wall
			w.xe = w.xs;
			w.ye = w.ys;
		end
		return w;
	endfunction

	task automatic send_random_query();
		int    n, r, slot;
		wall_t w;
		logic [COORD_W-1:0] cx, cy;
		n = (wall_count_shadow > WALLS) ? WALLS : int'(wall_count_shadow);
		r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, COORD_MAX)
		                                : $urandom_range(0, 200);
		if (n > 0 && $urandom_range(0, 4) != 0) begin
			// aim near an end of a tested wall so crossings land in and around its span
			slot = $urandom_range(0, n - 1);
			w = wall_shadow[slot];
			cx = clip_coord(int'($urandom_range(0, 1) ? w.xs : w.xe)
				+ int'($urandom_range(0, 2 * r + 20)) - r - 10);
			cy = clip_coord(int'($urandom_range(0, 1) ? w.ys : w.ye)
				+ int'($urandom_range(0, 2 * r + 20)) - r - 10);
		end else begin
			cx = rnd_coord();
			cy = rnd_coord();
		end
		send_item(OP_QUERY, INDEX_W'($urandom_range(0, WALLS - 1)), random_wall(), cx, cy,
			COORD_W'(r), 1'b0, 1'b0);
	endtask

	initial begin
		int                 phase, phase_len, new_count;
		stim_row_t          row;
		wall_t              w;
		logic [COUNT_W-1:0] count_val;

		arst_n            = 1'b0;
		s_tvalid          = 1'b0;
		s_tdata           = '0;
		s_tuser           = OP_LOAD;
		cfg_valid         = 1'b0;
		cfg_data          = '0;
		wall_count_shadow = '0;
		mismatches        = 0;
		items_sent        = 0;
		calm              = 1'b0;
		for (int i = 0; i < WALLS; i++)
			wall_shadow[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no walls tested: every position is free
		add_row(ROW_CFG,   0,  0, 0, 0, 0, 0, 0, 0);
		add_row(ROW_QUERY, 0,  0, 0, 0, 0, 0, 1, 1);
		add_row(ROW_QUERY, 0,  0, 4095, 4095, 4095, 0, 1, 1);
		// vertical, horizontal with reversed full-range ends, diagonal, point
		add_row(ROW_LOAD,  0,  0, 100, 50, 100, 200, 0, 0);
		add_row(ROW_LOAD,  0,  1, 4095, 3000, 0, 3000, 0, 0);
		add_row(ROW_LOAD,  0,  2, 0, 0, 4095, 4095, 0, 0);
		add_row(ROW_LOAD,  0, 63, 4095, 4095, 4095, 4095, 0, 0);
		add_row(ROW_CFG,   3,  0, 0, 0, 0, 0, 0, 0);
		// circle centered on the vertical wall, exact root, both crossings inside
		add_row(ROW_QUERY, 0,  0, 100, 100, 10, 0, 1, 0);
		add_row(ROW_QUERY, 0,  0, 90, 100, 10, 0, 0, 0);   // tangent
		add_row(ROW_QUERY, 0,  0, 2000, 2000, 5, 0, 1, 1);
		add_row(ROW_QUERY, 0,  0, 97, 50, 6, 0, 0, 0);     // non-exact root
		add_row(ROW_QUERY, 0,  0, 100, 40, 10, 0, 0, 0);   // crossing on the end point
		add_row(ROW_QUERY, 0,  0, 99, 2, 6, 0, 0, 0);      // lower crossing below zero
		add_row(ROW_QUERY, 0,  0, 0, 4095, 4095, 0, 0, 0);
		add_row(ROW_QUERY, 0,  0, 2048, 2990, 40, 0, 0, 0); // horizontal wall
		add_row(ROW_QUERY, 0,  0, 4095, 0, 0, 0, 0, 0);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_CFG: begin
					write_wall_count(row.count);
				end
				ROW_LOAD: begin
					w.xs = row.f0;
					w.ys = row.f1;
					w.xe = row.f2;
					w.ye = row.f3;
					send_item(OP_LOAD, row.slot, w, rnd_coord(), rnd_coord(), rnd_coord(),
						1'b0, 1'b0);
				end
				default: begin
					send_item(OP_QUERY, INDEX_W'($urandom_range(0, WALLS - 1)), random_wall(),
						row.f0, row.f1, row.f2, row.typed, row.typed_free);
				end
			endcase
		end

		// fill every slot so any count reads only written entries
		for (int i = 0; i < WALLS; i++)
			send_item(OP_LOAD, INDEX_W'(i), random_wall(), rnd_coord(), rnd_coord(),
				rnd_coord(), 1'b0, 1'b0);

		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			case (phase)
				0: new_count = 127;
				1: new_count = 64;
				2: new_count = 0;
				3: new_count = 1;
				default: new_count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
				                                                 : $urandom_range(1, 12);
			endcase
			count_val = COUNT_W'(new_count);
			write_wall_count(count_val);
			calm = ($urandom_range(0, 3) == 0);
			phase_len = (new_count > 12) ? $urandom_range(10, 20) : $urandom_range(20, 45);
			for (int k = 0; k < phase_len; k++) begin
				if ($urandom_range(0, 3) == 0)
					send_item(OP_LOAD, INDEX_W'($urandom_range(0, WALLS - 1)), random_wall(),
						rnd_coord(), rnd_coord(), rnd_coord(), 1'b0, 1'b0);
				else
					send_random_query();
				if ($urandom_range(0, 49) == 0)
					drain();
			end
			calm = 1'b0;
			phase++;
		end

		drain();
		repeat (2000) @(posedge clk);
		if (mismatches == 0 && free_expected.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
